FILE: rtl/mard_pkg.sv
// Shared constants, types and state encodings for the moving average / RMS detector.
package mard_pkg;

   // Ring store geometry
   localparam int HIST_DEPTH = 1024;
   localparam int HIST_AW    = $clog2(HIST_DEPTH);

   // Field and datapath widths
   localparam int WIN_W    = 11;
   localparam int SAMPLE_W = 16;
   localparam int LEVEL_W  = 17;
   localparam int ENTRY_W  = 31;
   localparam int SUM_W    = 42;
   localparam int MAG_W    = SUM_W - 1;
   localparam int RAD_W    = 32;
   localparam int ROOT_W   = RAD_W / 2;
   localparam int STEP_W   = $clog2(MAG_W);

   // Largest square (-32768 squared); every other entry with the top bit set is a negative sample
   localparam logic [ENTRY_W-1:0] ENTRY_SQ_MAX = ENTRY_W'(1) << (ENTRY_W - 1);

   // Job queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

   // Configuration registers
   localparam int                 CSR_IDX_W  = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_RMS    = CSR_IDX_W'(1);
   localparam logic [WIN_W-1:0]     WIN_RESET  = WIN_W'(1024);

   typedef enum logic [1:0] {
      FE_CLEAR,
      FE_IDLE,
      FE_UPDATE
   } fe_state_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_DIV,
      BK_SQRT,
      BK_OUT
   } bk_state_type;

   // One queued job: window sum after the update, divisor and mode
   typedef struct packed {
      logic signed [SUM_W-1:0] sum;
      logic [WIN_W-1:0]        window;
      logic                    rms;
   } mard_job_type;

endpackage

FILE: rtl/moving_average_rms_detector.sv
// Top level of the moving average / RMS level detector: configuration registers and front/back.
//
// Request channel (req_valid / req_ready / req_sample_in): one signed 16-bit sample per request.
// Response channel (rsp_valid / rsp_ready / rsp_level_out): one 17-bit signed level per request,
// in request order: the average of the last window_length stored values, truncated toward
// zero, or in RMS mode the floor square root of the mean of the stored squares.
// Config port (csr_we / csr_index / csr_wdata): index 0 window_length (1..1024, 0 acts as 1,
// larger values as 1024), index 1 rms_mode. Write only while no request is in flight.
// The front end takes a request, reads the ring entry leaving the window, writes the new one
// and updates the running sum, then queues the job (2 entries).
// The back end divides bit-serially and, in RMS mode, takes the square root two bits per
// cycle; it finishes one job before it takes the next, so the serial divider and root unit
// set the sustained rate. An RMS job whose sum is not positive skips both and gives level 0.
// After reset, and after every window_length write, the ring is cleared one entry per cycle:
// req_ready stays low meanwhile. Reset also sets window_length to 1024 and mode average.
// When the receiver stalls, the result holds in its register; the front keeps accepting
// requests until the job queue fills, then req_ready drops.
module moving_average_rms_detector (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic signed [mard_pkg::SAMPLE_W-1:0]  req_sample_in,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic signed [mard_pkg::LEVEL_W-1:0]   rsp_level_out,
   input  logic                                  csr_we,
   input  logic [mard_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [mard_pkg::WIN_W-1:0]            csr_wdata
);

   logic [mard_pkg::WIN_W-1:0] window_ff;
   logic                       rms_ff;
   logic                       clear_start;

   logic                       push_valid, push_ready;
   logic                       pop_valid, pop_ready;
   mard_pkg::mard_job_type     push_job, pop_job;

   // A window write restarts the ring clear
   assign clear_start = csr_we && (csr_index == mard_pkg::CSR_WINDOW);

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= mard_pkg::WIN_RESET;
         rms_ff    <= 1'b0;
      end else if (csr_we) begin
         case (csr_index)
            mard_pkg::CSR_WINDOW: window_ff <= csr_wdata;
            mard_pkg::CSR_RMS:    rms_ff    <= csr_wdata[0];
            default: begin
               rms_ff <= rms_ff;
            end
         endcase
      end
   end

   mard_front u_front (
      .clock         (clock),
      .reset         (reset),
      .clear_start   (clear_start),
      .window_length (window_ff),
      .rms_mode      (rms_ff),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_sample_in (req_sample_in),
      .push_ready    (push_ready),
      .push_valid    (push_valid),
      .push_job      (push_job)
   );

   mard_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_job   (push_job),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_job    (pop_job)
   );

   mard_back u_back (
      .clock         (clock),
      .reset         (reset),
      .pop_valid     (pop_valid),
      .pop_ready     (pop_ready),
      .pop_job       (pop_job),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_level_out (rsp_level_out)
   );

endmodule

FILE: rtl/mard_front.sv
// Front end: accepts requests, updates the history ring and running sum, queues jobs.
module mard_front (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                clear_start,
   input  logic [mard_pkg::WIN_W-1:0]          window_length,
   input  logic                                rms_mode,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic signed [mard_pkg::SAMPLE_W-1:0] req_sample_in,
   input  logic                                push_ready,
   output logic                                push_valid,
   output mard_pkg::mard_job_type              push_job
);

   // Stored entry back to a signed sum term
   function automatic logic signed [mard_pkg::SUM_W-1:0] entry_value(
      input logic [mard_pkg::ENTRY_W-1:0] e);
      if (e == mard_pkg::ENTRY_SQ_MAX) begin
         entry_value = {{(mard_pkg::SUM_W - mard_pkg::ENTRY_W){1'b0}}, e};
      end else begin
         entry_value = {{(mard_pkg::SUM_W - mard_pkg::ENTRY_W){e[mard_pkg::ENTRY_W-1]}}, e};
      end
   endfunction

   mard_pkg::fe_state_type state_ff, state_in;

   logic [mard_pkg::HIST_AW-1:0]        clr_addr_ff;
   logic [mard_pkg::HIST_AW-1:0]        wr_idx_ff;
   logic signed [mard_pkg::SUM_W-1:0]   sum_ff, sum_in;
   logic [mard_pkg::ENTRY_W-1:0]        entry_ff, entry_in;
   logic [mard_pkg::ENTRY_W-1:0]        rd_data_ff;

   logic [mard_pkg::ENTRY_W-1:0]        mem [0:mard_pkg::HIST_DEPTH-1];

   logic                                mem_we;
   logic [mard_pkg::HIST_AW-1:0]        mem_waddr;
   logic [mard_pkg::ENTRY_W-1:0]        mem_wdata;
   logic [mard_pkg::HIST_AW-1:0]        rd_addr;
   logic [mard_pkg::WIN_W-1:0]          eff_win;
   logic signed [2*mard_pkg::SAMPLE_W-1:0] square;
   logic                                accept;

   // Effective window clamped to 1..depth
   always_comb begin
      if (window_length == '0) begin
         eff_win = mard_pkg::WIN_W'(1);
      end else if (window_length > mard_pkg::WIN_W'(mard_pkg::HIST_DEPTH)) begin
         eff_win = mard_pkg::WIN_W'(mard_pkg::HIST_DEPTH);
      end else begin
         eff_win = window_length;
      end
   end

   // Trailing entry leaves the window; read it while waiting for a request
   assign rd_addr = wr_idx_ff - eff_win[mard_pkg::HIST_AW-1:0];

   assign accept = req_valid && req_ready;

   // New entry: sample or its square
   assign square = req_sample_in * req_sample_in;
   always_comb begin
      if (rms_mode) begin
         entry_in = square[mard_pkg::ENTRY_W-1:0];
      end else begin
         entry_in = {{(mard_pkg::ENTRY_W - mard_pkg::SAMPLE_W){req_sample_in[mard_pkg::SAMPLE_W-1]}},
                     req_sample_in};
      end
   end

   assign sum_in = sum_ff - entry_value(rd_data_ff) + entry_value(entry_ff);

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         mard_pkg::FE_CLEAR: begin
            if (clr_addr_ff == mard_pkg::HIST_AW'(mard_pkg::HIST_DEPTH - 1)) begin
               state_in = mard_pkg::FE_IDLE;
            end
         end
         mard_pkg::FE_IDLE: begin
            if (accept) begin
               state_in = mard_pkg::FE_UPDATE;
            end
         end
         mard_pkg::FE_UPDATE: begin
            state_in = mard_pkg::FE_IDLE;
         end
         default: begin
            state_in = mard_pkg::FE_CLEAR;
         end
      endcase
      if (clear_start) begin
         state_in = mard_pkg::FE_CLEAR;
      end
   end

   // Outputs
   always_comb begin
      req_ready  = 1'b0;
      mem_we     = 1'b0;
      mem_waddr  = wr_idx_ff;
      mem_wdata  = entry_ff;
      push_valid = 1'b0;
      case (state_ff)
         mard_pkg::FE_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_addr_ff;
            mem_wdata = '0;
         end
         mard_pkg::FE_IDLE: begin
            req_ready = push_ready;
         end
         mard_pkg::FE_UPDATE: begin
            mem_we     = 1'b1;
            push_valid = 1'b1;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   assign push_job.sum    = sum_in;
   assign push_job.window = eff_win;
   assign push_job.rms    = rms_mode;

   // History ring memory
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= mem[rd_addr];
   end

   // Control and sum registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= mard_pkg::FE_CLEAR;
         clr_addr_ff <= '0;
         wr_idx_ff   <= '0;
         sum_ff      <= '0;
      end else begin
         state_ff <= state_in;
         if (clear_start) begin
            clr_addr_ff <= '0;
            wr_idx_ff   <= '0;
            sum_ff      <= '0;
         end else begin
            if (state_ff == mard_pkg::FE_CLEAR) begin
               clr_addr_ff <= clr_addr_ff + 1'b1;
            end
            if (state_ff == mard_pkg::FE_UPDATE) begin
               wr_idx_ff <= wr_idx_ff + 1'b1;
               sum_ff    <= sum_in;
            end
         end
      end
   end

   // Entry captured with the request
   always_ff @(posedge clock) begin
      if (accept) begin
         entry_ff <= entry_in;
      end
   end

endmodule

FILE: rtl/mard_queue.sv
// Short job queue between the front end and the divide / square-root back end.
module mard_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push_valid,
   output logic                   push_ready,
   input  mard_pkg::mard_job_type push_job,
   output logic                   pop_valid,
   input  logic                   pop_ready,
   output mard_pkg::mard_job_type pop_job
);

   mard_pkg::mard_job_type          slots_ff [0:mard_pkg::QUEUE_DEPTH-1];
   logic [mard_pkg::QUEUE_AW-1:0]   wr_ptr_ff;
   logic [mard_pkg::QUEUE_AW-1:0]   rd_ptr_ff;
   logic [mard_pkg::QUEUE_CW-1:0]   count_ff;
   logic                            do_push, do_pop;

   assign push_ready = count_ff != mard_pkg::QUEUE_CW'(mard_pkg::QUEUE_DEPTH);
   assign pop_valid  = count_ff != '0;
   assign pop_job    = slots_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   // Storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wr_ptr_ff] <= push_job;
      end
   end

   // Pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            if (wr_ptr_ff == mard_pkg::QUEUE_AW'(mard_pkg::QUEUE_DEPTH - 1)) begin
               wr_ptr_ff <= '0;
            end else begin
               wr_ptr_ff <= wr_ptr_ff + 1'b1;
            end
         end
         if (do_pop) begin
            if (rd_ptr_ff == mard_pkg::QUEUE_AW'(mard_pkg::QUEUE_DEPTH - 1)) begin
               rd_ptr_ff <= '0;
            end else begin
               rd_ptr_ff <= rd_ptr_ff + 1'b1;
            end
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

FILE: rtl/mard_back.sv
// Back end: bit-serial divide by the window, optional integer square root, result register.
module mard_back (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 pop_valid,
   output logic                                 pop_ready,
   input  mard_pkg::mard_job_type               pop_job,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic signed [mard_pkg::LEVEL_W-1:0]  rsp_level_out
);

   mard_pkg::bk_state_type state_ff, state_in;

   logic [mard_pkg::MAG_W-1:0]    dvd_ff, dvd_in;
   logic [mard_pkg::WIN_W-1:0]    rem_ff, rem_in;
   logic [mard_pkg::WIN_W-1:0]    win_ff;
   logic                          neg_ff;
   logic                          rms_ff;
   logic [mard_pkg::STEP_W-1:0]   step_ff;
   logic [mard_pkg::RAD_W-1:0]    rad_ff;
   logic [mard_pkg::ROOT_W+1:0]   srem_ff, srem_in;
   logic [mard_pkg::ROOT_W-1:0]   root_ff, root_in;
   logic signed [mard_pkg::LEVEL_W-1:0] level_ff;

   logic                          take;
   logic                          sum_nonpos;
   logic [mard_pkg::SUM_W-1:0]    abs_sum;
   logic                          div_last, sqrt_last;
   logic [mard_pkg::WIN_W:0]      rem_sh;
   logic                          div_ge;
   logic [mard_pkg::ROOT_W+3:0]   srem_sh;
   logic [mard_pkg::ROOT_W+3:0]   trial;
   logic                          sq_ge;
   logic [mard_pkg::LEVEL_W-1:0]  quot;

   assign take       = pop_valid && pop_ready;
   assign sum_nonpos = pop_job.sum[mard_pkg::SUM_W-1] || (pop_job.sum == '0);
   assign abs_sum    = pop_job.sum[mard_pkg::SUM_W-1] ? -pop_job.sum : pop_job.sum;
   assign div_last   = step_ff == mard_pkg::STEP_W'(mard_pkg::MAG_W - 1);
   assign sqrt_last  = step_ff == mard_pkg::STEP_W'(mard_pkg::ROOT_W - 1);

   // Restoring division step: one quotient bit
   always_comb begin
      rem_sh = {rem_ff, dvd_ff[mard_pkg::MAG_W-1]};
      div_ge = rem_sh >= {1'b0, win_ff};
      if (div_ge) begin
         rem_in = mard_pkg::WIN_W'(rem_sh - {1'b0, win_ff});
      end else begin
         rem_in = rem_sh[mard_pkg::WIN_W-1:0];
      end
      dvd_in = {dvd_ff[mard_pkg::MAG_W-2:0], div_ge};
   end

   // Square root step: two radicand bits, one root bit
   always_comb begin
      srem_sh = {srem_ff, rad_ff[mard_pkg::RAD_W-1 -: 2]};
      trial   = {2'b00, root_ff, 2'b01};
      sq_ge   = srem_sh >= trial;
      if (sq_ge) begin
         srem_in = (mard_pkg::ROOT_W + 2)'(srem_sh - trial);
      end else begin
         srem_in = srem_sh[mard_pkg::ROOT_W+1:0];
      end
      root_in = {root_ff[mard_pkg::ROOT_W-2:0], sq_ge};
   end

   assign quot = dvd_in[mard_pkg::LEVEL_W-1:0];

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         mard_pkg::BK_IDLE: begin
            if (take) begin
               if (pop_job.rms && sum_nonpos) begin
                  state_in = mard_pkg::BK_OUT;
               end else begin
                  state_in = mard_pkg::BK_DIV;
               end
            end
         end
         mard_pkg::BK_DIV: begin
            if (div_last) begin
               state_in = rms_ff ? mard_pkg::BK_SQRT : mard_pkg::BK_OUT;
            end
         end
         mard_pkg::BK_SQRT: begin
            if (sqrt_last) begin
               state_in = mard_pkg::BK_OUT;
            end
         end
         mard_pkg::BK_OUT: begin
            if (rsp_ready) begin
               state_in = mard_pkg::BK_IDLE;
            end
         end
         default: begin
            state_in = mard_pkg::BK_IDLE;
         end
      endcase
   end

   // Outputs
   always_comb begin
      pop_ready = 1'b0;
      rsp_valid = 1'b0;
      case (state_ff)
         mard_pkg::BK_IDLE: pop_ready = 1'b1;
         mard_pkg::BK_OUT:  rsp_valid = 1'b1;
         default: begin
            pop_ready = 1'b0;
            rsp_valid = 1'b0;
         end
      endcase
   end

   assign rsp_level_out = level_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mard_pkg::BK_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Datapath
   always_ff @(posedge clock) begin
      case (state_ff)
         mard_pkg::BK_IDLE: begin
            dvd_ff  <= abs_sum[mard_pkg::MAG_W-1:0];
            rem_ff  <= '0;
            win_ff  <= pop_job.window;
            neg_ff  <= pop_job.sum[mard_pkg::SUM_W-1];
            rms_ff  <= pop_job.rms;
            step_ff <= '0;
            level_ff <= '0;
         end
         mard_pkg::BK_DIV: begin
            dvd_ff  <= dvd_in;
            rem_ff  <= rem_in;
            if (div_last) begin
               step_ff <= '0;
               rad_ff  <= {{(mard_pkg::RAD_W - mard_pkg::ENTRY_W){1'b0}},
                           dvd_in[mard_pkg::ENTRY_W-1:0]};
               srem_ff <= '0;
               root_ff <= '0;
               level_ff <= neg_ff ? -quot : quot;
            end else begin
               step_ff <= step_ff + 1'b1;
            end
         end
         mard_pkg::BK_SQRT: begin
            rad_ff  <= {rad_ff[mard_pkg::RAD_W-3:0], 2'b00};
            srem_ff <= srem_in;
            root_ff <= root_in;
            step_ff <= step_ff + 1'b1;
            if (sqrt_last) begin
               level_ff <= {1'b0, root_in};
            end
         end
         default: begin
            level_ff <= level_ff;
         end
      endcase
   end

endmodule

FILE: dv/moving_average_rms_detector_test.sv
// Self-checking testbench for the moving average / RMS level detector.
`timescale 1ns / 100ps

module moving_average_rms_detector_test;

   localparam logic signed [mard_pkg::SAMPLE_W-1:0] SAMPLE_MAX  = 16'sh7FFF;
   localparam logic signed [mard_pkg::SAMPLE_W-1:0] SAMPLE_MIN  = 16'sh8000;
   localparam logic [mard_pkg::CSR_IDX_W-1:0]       CSR_SPARE_A = mard_pkg::CSR_IDX_W'(2);
   localparam logic [mard_pkg::CSR_IDX_W-1:0]       CSR_SPARE_B = mard_pkg::CSR_IDX_W'(3);
   localparam int                                   HOLD_CYCLES = 600;
   localparam int                                   DRAIN_LIMIT = 20000;
   localparam int                                   TAIL_CYCLES = 70;

   typedef enum logic {
      ROW_WRITE,
      ROW_SAMPLE
   } row_kind_type;

   // One row of the directed table: a register write or a sample request
   typedef struct {
      row_kind_type                           kind;
      logic [mard_pkg::CSR_IDX_W-1:0]         index;
      logic [mard_pkg::WIN_W-1:0]             data;
      logic signed [mard_pkg::SAMPLE_W-1:0]   sample;
      bit                                     known;
      logic signed [mard_pkg::LEVEL_W-1:0]    level;
   } dir_row_type;

   logic                                   clock = 1'b0;
   logic                                   reset = 1'b1;
   logic                                   req_valid = 1'b0;
   logic                                   req_ready;
   logic signed [mard_pkg::SAMPLE_W-1:0]   req_sample_in = '0;
   logic                                   rsp_valid;
   logic                                   rsp_ready = 1'b0;
   logic signed [mard_pkg::LEVEL_W-1:0]    rsp_level_out;
   logic                                   csr_we = 1'b0;
   logic [mard_pkg::CSR_IDX_W-1:0]         csr_index = mard_pkg::CSR_WINDOW;
   logic [mard_pkg::WIN_W-1:0]             csr_wdata = '0;

   // Levels still owed by the block, oldest first
   logic signed [mard_pkg::LEVEL_W-1:0]    pending_levels[$];
   int                                     mismatch_count = 0;
   int                                     send_idle_pct = 0;
   int                                     stall_pct = 0;
   bit                                     hold_go = 1'b0;
   bit                                     hold_on = 1'b0;
   dir_row_type                            dir_rows[$];

   // Shadow of the block's ring, running sum and registers
   logic signed [mard_pkg::SUM_W-1:0]      ring_model [mard_pkg::HIST_DEPTH];
   logic [mard_pkg::HIST_AW-1:0]           ring_ptr;
   logic signed [mard_pkg::SUM_W-1:0]      ring_sum;
   logic [mard_pkg::WIN_W-1:0]             win_reg;
   logic                                   rms_reg;

   moving_average_rms_detector u_top (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_sample_in (req_sample_in),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_level_out (rsp_level_out),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata)
   );

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   function automatic void clear_ring();
      foreach (ring_model[i]) ring_model[i] = '0;
      ring_ptr = '0;
      ring_sum = '0;
   endfunction

   // Push one sample through the shadow ring and return the level it produces
   function automatic logic signed [mard_pkg::LEVEL_W-1:0] predict_level(
      input logic signed [mard_pkg::SAMPLE_W-1:0] s);
      int                                  w;
      logic [mard_pkg::HIST_AW-1:0]        trail;
      logic signed [mard_pkg::SUM_W-1:0]   wide;
      logic signed [mard_pkg::SUM_W-1:0]   entry;
      logic signed [mard_pkg::SUM_W-1:0]   divisor;
      logic signed [mard_pkg::SUM_W-1:0]   quot;
      longint                              root;
      longint                              trial;
      w = (win_reg == '0) ? 1 :
          (win_reg > mard_pkg::HIST_DEPTH) ? mard_pkg::HIST_DEPTH : int'(win_reg);
      trail = ring_ptr - mard_pkg::HIST_AW'(w);
      wide = mard_pkg::SUM_W'(s);
      entry = rms_reg ? wide * wide : wide;
      ring_sum = ring_sum - ring_model[trail];
      ring_model[ring_ptr] = entry;
      ring_sum = ring_sum + entry;
      ring_ptr = ring_ptr + 1'b1;
      divisor = mard_pkg::SUM_W'(w);
      quot = ring_sum / divisor;
      if (!rms_reg) return quot[mard_pkg::LEVEL_W-1:0];
      if (ring_sum <= 0) return '0;
      // floor square root, one bit at a time from the top
      root = 0;
      for (int b = mard_pkg::ROOT_W; b >= 0; b--) begin
         trial = root | (longint'(1) << b);
         if (trial * trial <= longint'(quot)) root = trial;
      end
      return mard_pkg::LEVEL_W'(root);
   endfunction

   function automatic dir_row_type write_row(input logic [mard_pkg::CSR_IDX_W-1:0] idx,
                                             input logic [mard_pkg::WIN_W-1:0] data);
      dir_row_type r;
      r = '{kind: ROW_WRITE, index: idx, data: data, sample: '0, known: 1'b0, level: '0};
      return r;
   endfunction

   function automatic dir_row_type sample_row(input logic signed [mard_pkg::SAMPLE_W-1:0] s,
                                              input bit known,
                                              input logic signed [mard_pkg::LEVEL_W-1:0] level);
      dir_row_type r;
      r = '{kind: ROW_SAMPLE, index: mard_pkg::CSR_WINDOW, data: '0, sample: s, known: known,
            level: level};
      return r;
   endfunction

   function automatic logic [mard_pkg::WIN_W-1:0] pick_window();
      case ($urandom_range(7))
         0: return '0;
         1: return mard_pkg::WIN_RESET;
         2: return '1;
         3, 4, 5: return mard_pkg::WIN_W'($urandom_range(8, 1));
         default: return mard_pkg::WIN_W'($urandom_range(1023, 1));
      endcase
   endfunction

   // Register write once all outstanding requests have been answered
   task automatic write_csr(input logic [mard_pkg::CSR_IDX_W-1:0] idx,
                            input logic [mard_pkg::WIN_W-1:0] data);
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_levels.size() != 0);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      if (idx == mard_pkg::CSR_WINDOW) begin
         win_reg = data;
         clear_ring();
      end else if (idx == mard_pkg::CSR_RMS) begin
         rms_reg = data[0];
      end
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // Offer one request, optionally after an idle gap; valid stays up after acceptance
   task automatic send_sample(input logic signed [mard_pkg::SAMPLE_W-1:0] s, input bit known,
                              input logic signed [mard_pkg::LEVEL_W-1:0] typed_level);
      logic signed [mard_pkg::LEVEL_W-1:0] lvl;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_sample_in <= s;
      do @(posedge clock); while (req_ready !== 1'b1);
      lvl = predict_level(s);
      pending_levels.push_back(known ? typed_level : lvl);
   endtask

   task automatic run_phase(input int n, input int idle, input int stall, input bit pressure);
      logic signed [mard_pkg::SAMPLE_W-1:0] s;
      send_idle_pct = idle;
      stall_pct <= stall;
      if (pressure) hold_go <= 1'b1;
      for (int i = 0; i < n; i++) begin
         case ($urandom_range(9))
            0: s = SAMPLE_MAX;
            1: s = SAMPLE_MIN;
            2: s = mard_pkg::SAMPLE_W'(int'($urandom_range(16)) - 8);
            default: s = mard_pkg::SAMPLE_W'($urandom);
         endcase
         send_sample(s, 1'b0, '0);
      end
   endtask

   // Long receiver hold-off, counted on its own
   initial begin
      wait (hold_go);
      @(posedge clock);
      hold_on <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      hold_on <= 1'b0;
   end

   // Response side: check each level, then pick the next ready
   always @(posedge clock) begin
      logic signed [mard_pkg::LEVEL_W-1:0] want;
      if (rsp_valid === 1'b1 && rsp_ready) begin
         if (pending_levels.size() == 0) begin
            $error("level_out: no request outstanding, actual %0d", rsp_level_out);
            mismatch_count++;
         end else begin
            want = pending_levels.pop_front();
            if (rsp_level_out !== want) begin
               $error("level_out: expected %0d, actual %0d", want, rsp_level_out);
               mismatch_count++;
            end
         end
      end
      if (hold_on) begin
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   initial begin
      win_reg = mard_pkg::WIN_RESET;
      rms_reg = 1'b0;
      clear_ring();

      // after reset, extremes, window edge cases, mode switch over a mixed ring
      dir_rows.push_back(sample_row(SAMPLE_MAX, 1'b1, 17'sd31));
      dir_rows.push_back(sample_row(SAMPLE_MIN, 1'b1, 17'sd0));
      dir_rows.push_back(write_row(mard_pkg::CSR_WINDOW, mard_pkg::WIN_W'(1)));
      dir_rows.push_back(sample_row(SAMPLE_MAX, 1'b1, 17'sd32767));
      dir_rows.push_back(sample_row(SAMPLE_MIN, 1'b1, -17'sd32768));
      dir_rows.push_back(sample_row(16'sd0, 1'b1, 17'sd0));
      dir_rows.push_back(write_row(mard_pkg::CSR_RMS, mard_pkg::WIN_W'(1)));
      dir_rows.push_back(sample_row(SAMPLE_MIN, 1'b1, 17'sd32768));
      dir_rows.push_back(sample_row(SAMPLE_MAX, 1'b1, 17'sd32767));
      dir_rows.push_back(sample_row(16'sd0, 1'b1, 17'sd0));
      dir_rows.push_back(write_row(mard_pkg::CSR_WINDOW, '0));
      dir_rows.push_back(sample_row(-16'sd5, 1'b1, 17'sd5));
      dir_rows.push_back(sample_row(16'sd1, 1'b1, 17'sd1));
      dir_rows.push_back(write_row(mard_pkg::CSR_WINDOW, mard_pkg::WIN_W'(2)));
      dir_rows.push_back(sample_row(16'sd100, 1'b0, '0));
      dir_rows.push_back(write_row(mard_pkg::CSR_RMS, '0));
      dir_rows.push_back(sample_row(-16'sd7, 1'b0, '0));
      dir_rows.push_back(write_row(mard_pkg::CSR_RMS, '1));
      // negative running sum in rms mode
      dir_rows.push_back(sample_row(16'sd1, 1'b0, '0));
      dir_rows.push_back(write_row(CSR_SPARE_A, '1));
      dir_rows.push_back(sample_row(16'sd9, 1'b0, '0));
      dir_rows.push_back(write_row(CSR_SPARE_B, '0));
      dir_rows.push_back(write_row(mard_pkg::CSR_WINDOW, '1));
      dir_rows.push_back(sample_row(SAMPLE_MIN, 1'b0, '0));
      dir_rows.push_back(sample_row(16'sh5555, 1'b0, '0));
      dir_rows.push_back(write_row(mard_pkg::CSR_RMS, mard_pkg::WIN_W'(2)));
      dir_rows.push_back(sample_row(16'shAAAA, 1'b0, '0));
      dir_rows.push_back(sample_row(SAMPLE_MAX, 1'b0, '0));

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_rows[i]) begin
         if (dir_rows[i].kind == ROW_WRITE) begin
            write_csr(dir_rows[i].index, dir_rows[i].data);
         end else begin
            send_sample(dir_rows[i].sample, dir_rows[i].known, dir_rows[i].level);
         end
      end

      // random phases; the first three share one window so the ring pointer wraps
      write_csr(mard_pkg::CSR_WINDOW, pick_window());
      write_csr(mard_pkg::CSR_RMS, mard_pkg::WIN_W'($urandom));
      run_phase(450, 0, 0, 1'b0);
      write_csr(mard_pkg::CSR_RMS, mard_pkg::WIN_W'($urandom));
      run_phase(300, 82, 0, 1'b0);
      write_csr(CSR_SPARE_A, mard_pkg::WIN_W'($urandom));
      write_csr(mard_pkg::CSR_RMS, mard_pkg::WIN_W'($urandom));
      run_phase(300, 0, 82, 1'b0);
      write_csr(mard_pkg::CSR_WINDOW, pick_window());
      write_csr(mard_pkg::CSR_RMS, mard_pkg::WIN_W'($urandom));
      run_phase(150, 35, 35, 1'b0);
      // long receiver hold-off while requests keep coming
      write_csr(mard_pkg::CSR_WINDOW, pick_window());
      write_csr(mard_pkg::CSR_RMS, mard_pkg::WIN_W'($urandom));
      run_phase(60, 0, 0, 1'b1);
      req_valid <= 1'b0;

      for (int i = 0; i < DRAIN_LIMIT && pending_levels.size() != 0; i++) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (pending_levels.size() != 0) begin
         $error("level_out: expected %0d more, actual none", pending_levels.size());
         mismatch_count++;
      end
      if (mismatch_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #20_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

FILE: files.f
rtl/mard_pkg.sv
rtl/mard_front.sv
rtl/mard_queue.sv
rtl/mard_back.sv
rtl/moving_average_rms_detector.sv
dv/moving_average_rms_detector_test.sv
